@@ rtl/core/mmsd_pkg.sv @@
// Package for the motion magnitude swing detector.
// Holds the payload structs, sizing constants and the axis sign-extension helper.
// No dependencies.
`default_nettype none

package mmsd_pkg;

    localparam int SAMPLE_BITS = 16;

    localparam logic [16:0] LEVEL_ONE       = 17'd65536;
    localparam logic [16:0] SWING_LEVEL_RST = 17'd22938;   // 0.35 in Q0.16
    localparam logic [15:0] LOW_MARK_RST    = 16'hFFFF;
    localparam logic [15:0] HIGH_MARK_RST   = 16'h0000;
    localparam logic [15:0] SWING_TOTAL_MAX = 16'hFFFF;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } mmsd_in_t;

    typedef struct packed {
        logic [15:0] magnitude;
        logic [16:0] level;
        logic        swing_event;
        logic        in_swing;
        logic [15:0] total_swings;
    } mmsd_out_t;

    localparam logic CMD_CAL = 1'b0;
    localparam logic CMD_DET = 1'b1;

    // Keep the low SAMPLE_BITS bits and sign-extend from the top one.
    function automatic logic signed [15:0] sext_axis(input logic [15:0] raw);
        logic [15:0] up;
        begin
            up = raw << (16 - SAMPLE_BITS);
            sext_axis = $signed(up) >>> (16 - SAMPLE_BITS);
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/motion_magnitude_swing_detector.sv @@
// Motion magnitude swing detector, top level.
// Depends on mmsd_pkg (payload structs, constants, sign extension).
//
// Usage: one three-axis sample per transfer on s_valid/s_ready (s_data).
// cmd 0 widens the calibration range of magnitudes, cmd 1 maps the magnitude
// into that range as a Q0.16 level and runs the swing arm/fire logic.
// Exactly one result per sample leaves on m_valid/m_ready (m_data).
// cfg_we/cfg_wdata write the Q0.16 threshold; write only while idle.
// Steps: squaring on the shared multiplier, bit-pair square root, one range
// check, for detection samples inside the range restoring division through
// one shared subtractor, for all detection samples the swing update, and
// then the output load. s_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new sample can be taken while
// it waits; if the receiver stalls, the following result holds in the final
// step until the output register frees up.
// Reset (aresetn low, synchronous) empties the output, clears the swing
// state, sets the calibration range to empty and the threshold to 0.35.
`default_nettype none

module motion_magnitude_swing_detector (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire mmsd_pkg::mmsd_in_t  s_data,
    output      logic                m_valid,
    input  wire logic                m_ready,
    output      mmsd_pkg::mmsd_out_t m_data,
    input  wire logic                cfg_we,
    input  wire logic [16:0]         cfg_wdata
);
    import mmsd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_ROOT  = 3'd2;
    localparam logic [2:0] ST_CLASS = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_EVAL  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]  state_reg,   state_next;
    logic [3:0]  cnt_reg,     cnt_next;
    mmsd_in_t    in_reg,      in_next;
    logic [31:0] prod_reg,    prod_next;
    logic [31:0] sum_reg,     sum_next;     // sum of squares, shifted out by root steps
    logic [17:0] rrem_reg,    rrem_next;
    logic [15:0] root_reg,    root_next;    // magnitude once the root is done
    logic [15:0] drem_reg,    drem_next;
    logic [16:0] level_reg,   level_next;   // quotient shifts in here
    logic        event_reg,   event_next;
    logic [16:0] thr_reg,     thr_next;
    logic [15:0] low_reg,     low_next;
    logic [15:0] high_reg,    high_next;
    logic        active_reg,  active_next;
    logic [15:0] total_reg,   total_next;
    logic        m_valid_reg, m_valid_next;
    mmsd_out_t   m_data_reg,  m_data_next;

    logic signed [15:0] axis_sel;
    logic signed [31:0] sq;
    logic [19:0]        sub_a;
    logic [19:0]        sub_b;
    logic [20:0]        sub_diff;
    logic [15:0]        den;
    logic [1:0]         top2;
    logic               s_acc;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign den  = high_reg - low_reg;
    assign top2 = sum_reg[31:30];

    // Shared multiplier: one axis squared per cycle.
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    axis_sel = sext_axis(in_reg.accel_x);
            2'd1:    axis_sel = sext_axis(in_reg.accel_y);
            2'd2:    axis_sel = sext_axis(in_reg.accel_z);
            default: axis_sel = '0;
        endcase
    end
    assign sq = axis_sel * axis_sel;

    // Shared subtractor: root trial, offset from the low mark, division trial.
    always_comb begin
        case (state_reg)
            ST_ROOT: begin
                sub_a = {rrem_reg, top2};
                sub_b = {2'b00, root_reg, 2'b01};
            end
            ST_CLASS: begin
                sub_a = {4'd0, root_reg};
                sub_b = {4'd0, low_reg};
            end
            ST_DIV: begin
                sub_a = {3'd0, drem_reg, 1'b0};
                sub_b = {4'd0, den};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_next      = in_reg;
        prod_next    = prod_reg;
        sum_next     = sum_reg;
        rrem_next    = rrem_reg;
        root_next    = root_reg;
        drem_next    = drem_reg;
        level_next   = level_reg;
        event_next   = event_reg;
        thr_next     = cfg_we ? cfg_wdata : thr_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        active_next  = active_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    in_next    = s_data;
                    sum_next   = '0;
                    cnt_next   = '0;
                    level_next = '0;
                    event_next = 1'b0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                if (cnt_reg != 4'd0) begin
                    sum_next = sum_reg + prod_reg;
                end
                if (cnt_reg == 4'd3) begin
                    cnt_next   = '0;
                    rrem_next  = '0;
                    root_next  = '0;
                    state_next = ST_ROOT;
                end else begin
                    prod_next = $unsigned(sq);
                    cnt_next  = cnt_reg + 4'd1;
                end
            end
            ST_ROOT: begin
                if (!sub_diff[20]) begin
                    rrem_next = sub_diff[17:0];
                    root_next = {root_reg[14:0], 1'b1};
                end else begin
                    rrem_next = {rrem_reg[15:0], top2};
                    root_next = {root_reg[14:0], 1'b0};
                end
                sum_next = {sum_reg[29:0], 2'b00};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS: begin
                if (in_reg.cmd == CMD_CAL) begin
                    if (root_reg > high_reg) high_next = root_reg;
                    if (root_reg < low_reg)  low_next  = root_reg;
                    state_next = ST_DONE;
                end else if (high_reg <= low_reg) begin
                    state_next = ST_EVAL;   // uncalibrated: level stays 0
                end else if (root_reg <= low_reg) begin
                    state_next = ST_EVAL;
                end else if (root_reg >= high_reg) begin
                    level_next = LEVEL_ONE;
                    state_next = ST_EVAL;
                end else begin
                    drem_next  = sub_diff[15:0];
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!sub_diff[20]) begin
                    drem_next  = sub_diff[15:0];
                    level_next = {level_reg[15:0], 1'b1};
                end else begin
                    drem_next  = {drem_reg[14:0], 1'b0};
                    level_next = {level_reg[15:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!active_reg && (level_reg > thr_reg)) begin
                    active_next = 1'b1;
                    event_next  = 1'b1;
                    if (total_reg != SWING_TOTAL_MAX) begin
                        total_next = total_reg + 16'd1;
                    end
                end
                if (level_reg < thr_reg) begin
                    active_next = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.magnitude    = root_reg;
                    m_data_next.level        = level_reg;
                    m_data_next.swing_event  = event_reg;
                    m_data_next.in_swing     = active_reg;
                    m_data_next.total_swings = total_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            event_reg   <= 1'b0;
            thr_reg     <= SWING_LEVEL_RST;
            low_reg     <= LOW_MARK_RST;
            high_reg    <= HIGH_MARK_RST;
            active_reg  <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            event_reg   <= event_next;
            thr_reg     <= thr_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            active_reg  <= active_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        rrem_reg   <= rrem_next;
        root_reg   <= root_next;
        drem_reg   <= drem_next;
        level_reg  <= level_next;
        m_data_reg <= m_data_next;
    end

    // Level never exceeds 1.0 in Q0.16.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.level <= LEVEL_ONE))
        else $error("level above 1.0");

    // A firing sample always leaves the block in a swing.
    a_event_swing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.swing_event) |-> m_data.in_swing)
        else $error("swing event without swing flag");

    // The sequencer is busy in the cycle after a sample transfer.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready straight after a transfer");

    // Calibration samples never produce a level.
    a_cal_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && in_reg.cmd == CMD_CAL) |-> (level_reg == '0))
        else $error("calibration sample with non-zero level");

endmodule

`default_nettype wire
